@@ src/assert_macros.svh @@
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent holds
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bfop_pkg.sv @@
// Types, constants and helper functions for the bounded FIFO with overflow policy
package bfop_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = LVL_W + 1;
   localparam int CNT_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] OP_PUT_DATA = 2'd0;
   localparam logic [1:0] OP_PUT_CTRL = 2'd1;
   localparam logic [1:0] OP_GET      = 2'd2;
   localparam logic [1:0] OP_CLOSE    = 2'd3;

   localparam logic [1:0] POL_BLOCK       = 2'd0;
   localparam logic [1:0] POL_LATEST      = 2'd1;
   localparam logic [1:0] POL_DROP_OLDEST = 2'd2;
   localparam logic [1:0] POL_DROP_NEWEST = 2'd3;

   localparam logic [2:0] ST_DONE         = 3'd0;
   localparam logic [2:0] ST_REFUSED      = 3'd1;
   localparam logic [2:0] ST_WAIT_FULL    = 3'd2;
   localparam logic [2:0] ST_WAIT_EMPTY   = 3'd3;
   localparam logic [2:0] ST_CLOSED_EMPTY = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd1;

   localparam logic [4:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] item_data;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_data;
      logic [4:0]  depth_now;
      logic [31:0] count_in;
      logic [31:0] count_out;
      logic [31:0] count_dropped;
      logic [4:0]  peak_depth;
      logic        is_closed;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                input logic [LVL_W-1:0] n);
      logic [CNT_W:0] sum;
      sum = {1'b0, cnt} + (CNT_W+1)'(n);
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                input logic [LVL_W-1:0] n);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(ptr) + SUM_W'(n);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

@@ src/bfop_ctrl.sv @@
// Controller: sequences capture, execution and result handoff of one item
module bfop_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bfop_pkg::cmd_type cmd
);
   import bfop_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign cmd.load  = req_valid && (state_ff == S_IDLE);
   assign cmd.exec  = (state_ff == S_EXEC);

endmodule

@@ src/bfop_dpath.sv @@
// Datapath: slot memory, pointers, level, counters, config and result register
module bfop_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  bfop_pkg::cmd_type                   cmd,
   input  bfop_pkg::req_type                   req_data,
   output bfop_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [bfop_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfop_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bfop_pkg::*;

   logic [DATA_WIDTH-1:0] slot_mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [1:0]       policy_ff;
   logic [4:0]       capacity_ff;
   logic [1:0]       op_ff;
   logic [31:0]      word_ff;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [LVL_W-1:0] fill_ff, fill_in;
   logic [LVL_W-1:0] peak_ff, peak_in;
   logic             closed_ff, closed_in;
   logic [CNT_W-1:0] cnt_in_ff, cnt_in_in;
   logic [CNT_W-1:0] cnt_out_ff, cnt_out_in;
   logic [CNT_W-1:0] cnt_drop_ff, cnt_drop_in;
   rsp_type          rsp_ff, rsp_in;

   logic [LVL_W-1:0]      cap_eff;
   logic                  full;
   logic                  do_enq;
   logic [LVL_W-1:0]      evict_n;
   logic                  wr_en;
   logic [2:0]            status;
   logic [DATA_WIDTH-1:0] data_out;

   always_comb begin
      if (capacity_ff == 5'd0) begin
         cap_eff = LVL_W'(1);
      end else if (int'(capacity_ff) > DEPTH) begin
         cap_eff = LVL_W'(DEPTH);
      end else begin
         cap_eff = LVL_W'(capacity_ff);
      end
   end

   assign full = (fill_ff >= cap_eff);

   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      fill_in     = fill_ff;
      peak_in     = peak_ff;
      closed_in   = closed_ff;
      cnt_in_in   = cnt_in_ff;
      cnt_out_in  = cnt_out_ff;
      cnt_drop_in = cnt_drop_ff;
      status      = ST_DONE;
      data_out    = '0;
      do_enq      = 1'b0;
      evict_n     = '0;
      wr_en       = 1'b0;
      case (op_ff)
         OP_PUT_DATA: begin
            if (full && (policy_ff == POL_BLOCK)) begin
               status = closed_ff ? ST_REFUSED : ST_WAIT_FULL;
            end else if (full && (policy_ff == POL_DROP_NEWEST)) begin
               cnt_drop_in = sat_add(cnt_drop_ff, LVL_W'(1));
               status      = ST_REFUSED;
            end else begin
               if (full) begin
                  evict_n = (policy_ff == POL_LATEST) ? fill_ff
                                                      : fill_ff - cap_eff + LVL_W'(1);
               end
               rd_ptr_in   = ptr_add(rd_ptr_ff, evict_n);
               fill_in     = fill_ff - evict_n;
               cnt_drop_in = sat_add(cnt_drop_ff, evict_n);
               if (closed_ff) begin
                  status = ST_REFUSED;
               end else begin
                  do_enq = 1'b1;
               end
            end
         end
         OP_PUT_CTRL: begin
            if (closed_ff) begin
               status = ST_REFUSED;
            end else if (full) begin
               status = ST_WAIT_FULL;
            end else begin
               do_enq = 1'b1;
            end
         end
         OP_GET: begin
            if (fill_ff != '0) begin
               data_out   = rd_data_ff;
               rd_ptr_in  = ptr_add(rd_ptr_ff, LVL_W'(1));
               fill_in    = fill_ff - LVL_W'(1);
               cnt_out_in = sat_add(cnt_out_ff, LVL_W'(1));
            end else begin
               status = closed_ff ? ST_CLOSED_EMPTY : ST_WAIT_EMPTY;
            end
         end
         OP_CLOSE: begin
            closed_in = 1'b1;
         end
         default: begin
            status = ST_DONE;
         end
      endcase
      if (do_enq) begin
         wr_en     = cmd.exec;
         wr_ptr_in = ptr_add(wr_ptr_ff, LVL_W'(1));
         fill_in   = fill_in + LVL_W'(1);
         cnt_in_in = sat_add(cnt_in_ff, LVL_W'(1));
         if (fill_in > peak_ff) begin
            peak_in = fill_in;
         end
      end
      rsp_in.status        = status;
      rsp_in.out_data      = 32'(data_out);
      rsp_in.depth_now     = 5'(fill_in);
      rsp_in.count_in      = cnt_in_in;
      rsp_in.count_out     = cnt_out_in;
      rsp_in.count_dropped = cnt_drop_in;
      rsp_in.peak_depth    = 5'(peak_in);
      rsp_in.is_closed     = closed_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_ptr_ff] <= DATA_WIDTH'(word_ff);
      end
      rd_data_ff <= slot_mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_data.opcode;
         word_ff <= req_data.item_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= POL_BLOCK;
         capacity_ff <= CAP_RESET;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         fill_ff     <= '0;
         peak_ff     <= '0;
         closed_ff   <= 1'b0;
         cnt_in_ff   <= '0;
         cnt_out_ff  <= '0;
         cnt_drop_ff <= '0;
      end else begin
         if (csr_we && (csr_index == CSR_POLICY)) begin
            policy_ff <= csr_wdata[1:0];
         end
         if (csr_we && (csr_index == CSR_CAPACITY)) begin
            capacity_ff <= csr_wdata[4:0];
         end
         if (cmd.exec) begin
            rd_ptr_ff   <= rd_ptr_in;
            wr_ptr_ff   <= wr_ptr_in;
            fill_ff     <= fill_in;
            peak_ff     <= peak_in;
            closed_ff   <= closed_in;
            cnt_in_ff   <= cnt_in_in;
            cnt_out_ff  <= cnt_out_in;
            cnt_drop_ff <= cnt_drop_in;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ src/bounded_fifo_overflow_policy_top.sv @@
// Top level of the bounded FIFO with a configurable full-queue policy
//
// Request channel (req_): valid/stall, payload req_data with opcode
// (put data, put control, get, close) and item_data. Response channel
// (rsp_): valid/stall, one response item per request, carrying status,
// dequeued word, depth, saturating counters, peak depth and closed flag.
// Register port (csr_): index/write data with valid/ready; ready is
// always high. Index 0 is the overflow policy, index 1 the capacity.
//
// Timing: a request is taken in the idle state, executed in the next cycle
// in the execute state, and the response is presented in the output state.
// One request is in flight at a time; the three-state controller returns
// to idle only when the response is taken. req_stall stays high from
// acceptance until the response is taken.
// A stalled response holds its payload; no new request is taken until
// rsp_stall drops. Reset empties the queue, clears pointers, counters,
// peak and closed flag, and loads policy block and capacity 16.
module bounded_fifo_overflow_policy_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bfop_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bfop_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bfop_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfop_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bfop_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   bfop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bfop_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ src/bfop_checker.sv @@
// Port-level checks for the bounded FIFO top level
`include "assert_macros.svh"

module bfop_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bfop_pkg::rsp_type rsp_data
);
   import bfop_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "second item taken while one is in flight")
   `ASSERT_IMPL(a_rsp_after_req, clock, reset, $rose(rsp_valid), req_stall, "response without a pending item")
   `ASSERT_IMPL(a_peak_bound, clock, reset, rsp_valid, (rsp_data.peak_depth >= rsp_data.depth_now) && (rsp_data.depth_now <= 5'(DEPTH)), "depth exceeds peak or capacity")
   `ASSERT_IMPL(a_closed_empty, clock, reset, rsp_valid && (rsp_data.status == ST_CLOSED_EMPTY), rsp_data.is_closed && (rsp_data.depth_now == 5'd0), "closed_empty on open or nonempty queue")

endmodule

bind bounded_fifo_overflow_policy_top bfop_checker u_bfop_checker (.*);

@@ tb/sv/fifo_response_checker.sv @@
// Checker for the bounded FIFO: follows register writes, predicts each response item and compares
module fifo_response_checker
   import bfop_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  req_type                 req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  rsp_type                 rsp_data,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      mismatch_count,
   output int                      responses_due
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DATA_WIDTH-1:0] slots [DEPTH];
   int unsigned           head;
   int unsigned           tail;
   int unsigned           fill;
   int unsigned           peak;
   logic                  closed;
   logic [CNT_W-1:0]      n_in;
   logic [CNT_W-1:0]      n_out;
   logic [CNT_W-1:0]      n_drop;
   logic [1:0]            policy;
   logic [4:0]            capacity;
   rsp_type               due_rsps[$];

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c,
                                                input int unsigned n);
      longint unsigned s;
      s = longint'(c) + longint'(n);
      return (s > 64'hFFFF_FFFF) ? '1 : s[CNT_W-1:0];
   endfunction

   function automatic string rsp_text(input rsp_type v);
      return $sformatf("st=%0d data=%h depth=%0d in=%0d out=%0d drop=%0d peak=%0d closed=%0d",
                       v.status, v.out_data, v.depth_now, v.count_in, v.count_out,
                       v.count_dropped, v.peak_depth, v.is_closed);
   endfunction

   task automatic discard_oldest(input int unsigned n);
      if (n > fill) begin
         n = fill;
      end
      head   = (head + n) % DEPTH;
      fill   = fill - n;
      n_drop = sat_inc(n_drop, n);
   endtask

   task automatic store_word(input logic [DATA_WIDTH-1:0] w);
      slots[tail] = w;
      tail = (tail + 1) % DEPTH;
      fill = fill + 1;
      n_in = sat_inc(n_in, 1);
      if (fill > peak) begin
         peak = fill;
      end
   endtask

   task automatic fifo_step(input req_type r, output rsp_type e);
      int unsigned           cap;
      logic                  full;
      logic [2:0]            st;
      logic [DATA_WIDTH-1:0] dout;
      if (capacity == 0) begin
         cap = 1;
      end else if (capacity > DEPTH) begin
         cap = DEPTH;
      end else begin
         cap = capacity;
      end
      full = (fill >= cap);
      st   = ST_DONE;
      dout = '0;
      case (r.opcode)
         OP_PUT_DATA: begin
            if (full && policy == POL_BLOCK) begin
               st = closed ? ST_REFUSED : ST_WAIT_FULL;
            end else if (full && policy == POL_DROP_NEWEST) begin
               n_drop = sat_inc(n_drop, 1);
               st = ST_REFUSED;
            end else begin
               if (full && policy == POL_LATEST) begin
                  discard_oldest(fill);
               end else if (full) begin
                  discard_oldest(fill - cap + 1);
               end
               if (closed) begin
                  st = ST_REFUSED;
               end else begin
                  store_word(r.item_data);
               end
            end
         end
         OP_PUT_CTRL: begin
            if (closed) begin
               st = ST_REFUSED;
            end else if (full) begin
               st = ST_WAIT_FULL;
            end else begin
               store_word(r.item_data);
            end
         end
         OP_GET: begin
            if (fill > 0) begin
               dout  = slots[head];
               head  = (head + 1) % DEPTH;
               fill  = fill - 1;
               n_out = sat_inc(n_out, 1);
            end else begin
               st = closed ? ST_CLOSED_EMPTY : ST_WAIT_EMPTY;
            end
         end
         OP_CLOSE: begin
            closed = 1'b1;
         end
         default: begin
         end
      endcase
      e.status        = st;
      e.out_data      = dout;
      e.depth_now     = 5'(fill);
      e.count_in      = n_in;
      e.count_out     = n_out;
      e.count_dropped = n_drop;
      e.peak_depth    = 5'(peak);
      e.is_closed     = closed;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         head           = 0;
         tail           = 0;
         fill           = 0;
         peak           = 0;
         closed         = 1'b0;
         n_in           = '0;
         n_out          = '0;
         n_drop         = '0;
         policy         = POL_BLOCK;
         capacity       = CAP_RESET;
         mismatch_count = 0;
         due_rsps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (due_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: response item with none expected: %s", $realtime, rsp_text(got));
               end
            end else begin
               want = due_rsps.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("   expected %s", rsp_text(want));
                     $display("   actual   %s", rsp_text(got));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            fifo_step(req_data, want);
            due_rsps.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POLICY: begin
                  policy = csr_wdata[1:0];
               end
               CSR_CAPACITY: begin
                  capacity = csr_wdata[4:0];
               end
               default: begin
               end
            endcase
         end
      end
      responses_due = due_rsps.size();
   end

endmodule

@@ tb/sv/tb_bounded_fifo_overflow_policy_top.sv @@
// Testbench top for the bounded FIFO with overflow policy: stimulus, idling and verdict
module tb_bounded_fifo_overflow_policy_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bfop_pkg::*;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int responses_due;
   int gap_pct   = 19;
   int stall_pct = 65;
   int op_seen[4];
   int reg_writes;

   bounded_fifo_overflow_policy_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fifo_response_checker resp_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .responses_due  (responses_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      #3_000_000;
      $display("tb_bounded_fifo_overflow_policy_top NOT OK");
      $finish;
   end

   task automatic send_item(input logic [1:0] op, input logic [31:0] word);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = {op, word};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      op_seen[op]++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (responses_due != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_mode(input logic [1:0] pol, input logic [4:0] cap);
      drain_results();
      write_reg(CSR_POLICY, ($urandom() & ~32'h3) | 32'(pol));
      write_reg(CSR_CAPACITY, ($urandom() & ~32'h1F) | 32'(cap));
   endtask

   function automatic logic [4:0] pick_capacity();
      case ($urandom_range(0, 9))
         0:       return 5'd0;
         1:       return 5'($urandom_range(17, 31));
         2:       return 5'd16;
         3:       return 5'd1;
         default: return 5'($urandom_range(2, 6));
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic run_batch(input int n, input int put_pct, input logic with_close);
      int          r;
      logic [1:0]  op;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (with_close) begin
            op = 2'($urandom_range(0, 3));
         end else if (r < put_pct) begin
            op = (r % 4 == 0) ? OP_PUT_CTRL : OP_PUT_DATA;
         end else begin
            op = OP_GET;
         end
         send_item(op, pick_word());
      end
   endtask

   task automatic run_phase(input int gap, input int stall);
      gap_pct   = gap;
      stall_pct = stall;
      for (int b = 0; b < 6; b++) begin
         set_mode(2'($urandom_range(0, 3)), pick_capacity());
         run_batch(20, $urandom_range(30, 80), 1'b0);
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset configuration: block, capacity 16
      send_item(OP_GET, 32'h1234_5678);
      send_item(OP_PUT_DATA, 32'h0000_0000);
      send_item(OP_PUT_DATA, 32'hFFFF_FFFF);
      send_item(OP_PUT_CTRL, 32'h5A5A_A5A5);
      repeat (3) send_item(OP_GET, $urandom());

      set_mode(POL_BLOCK, 5'd2);
      repeat (3) send_item(OP_PUT_DATA, $urandom());
      send_item(OP_PUT_CTRL, $urandom());

      set_mode(POL_LATEST, 5'd2);
      send_item(OP_PUT_DATA, $urandom());
      send_item(OP_PUT_CTRL, $urandom());
      send_item(OP_PUT_CTRL, $urandom());

      set_mode(POL_DROP_OLDEST, 5'd4);
      repeat (3) send_item(OP_PUT_DATA, $urandom());

      // shrink below the fill level: evict several at once
      set_mode(POL_DROP_OLDEST, 5'd1);
      send_item(OP_PUT_DATA, $urandom());

      set_mode(POL_DROP_NEWEST, 5'd0);
      send_item(OP_PUT_DATA, $urandom());
      set_mode(POL_DROP_NEWEST, 5'd31);
      send_item(OP_PUT_DATA, $urandom());
      repeat (3) send_item(OP_GET, $urandom());

      run_phase(19, 65);
      run_phase(65, 19);
      run_phase(0, 0);

      // closed queue: eviction still happens before the refusal
      set_mode(POL_BLOCK, 5'd4);
      repeat (6) send_item(OP_PUT_DATA, pick_word());
      send_item(OP_CLOSE, $urandom());
      send_item(OP_PUT_DATA, $urandom());
      send_item(OP_PUT_CTRL, $urandom());
      set_mode(POL_DROP_NEWEST, 5'd4);
      send_item(OP_PUT_DATA, $urandom());
      set_mode(POL_DROP_OLDEST, 5'd3);
      send_item(OP_PUT_DATA, $urandom());
      send_item(OP_GET, $urandom());
      set_mode(POL_LATEST, 5'd1);
      send_item(OP_PUT_DATA, $urandom());
      send_item(OP_GET, $urandom());
      send_item(OP_CLOSE, $urandom());
      gap_pct   = 0;
      stall_pct = 0;
      for (int b = 0; b < 3; b++) begin
         set_mode(2'($urandom_range(0, 3)), pick_capacity());
         run_batch(10, 50, 1'b1);
      end

      req_valid = 1'b0;
      while (responses_due != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      $display("covered %0d items: %0d data puts, %0d control puts, %0d gets, %0d closes",
               op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
               op_seen[OP_PUT_DATA], op_seen[OP_PUT_CTRL], op_seen[OP_GET], op_seen[OP_CLOSE]);
      $display("%0d register writes over all four policies; %0d mismatches",
               reg_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_bounded_fifo_overflow_policy_top OK");
      end else begin
         $display("tb_bounded_fifo_overflow_policy_top NOT OK");
      end
      $finish;
   end

endmodule
